/* rtl/core/aoq_pkg.sv */
`default_nettype none

package aoq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } t_rec;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    // sort order: arrival first, then id
    function automatic logic rec_after(input t_rec a, input t_rec b);
        return {a.arrival, a.id} > {b.arrival, b.id};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/arrival_ordered_queue.sv */
`default_nettype none

// Sorted queue of process records, ordered by arrival time, then id.
// Requests: drive start high with i_operation (insert or pop) and the
// record fields; a request is taken at each rising edge where start is
// high and busy is low. busy stays low, so a request may be issued every
// cycle: throughput is one request per cycle.
// The cycle after a request o_strobe is high for one cycle with the head
// record after the operation, o_is_empty, o_entry_total and o_status
// (ok, insert dropped on full, pop on empty).
// An empty queue shows zeros in the head fields.
// Storage is a chain of QUEUE_DEPTH cells; on insert every cell compares
// its key with the new record at once and the later ones shift back by
// one, on pop all cells shift forward by one.
// Reset (synchronous, active low) empties the queue and clears the
// strobe. The receiver cannot stall; results not captured in their
// strobe cycle are gone.
module arrival_ordered_queue
    import aoq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_operation,
    input  wire logic [7:0]          i_proc_id,
    input  wire logic [15:0]         i_arrival_time,
    input  wire logic [15:0]         i_burst_length,
    input  wire logic [7:0]          i_prio_level,
    output logic                     o_strobe,
    output logic [7:0]               o_head_id,
    output logic [15:0]              o_head_arrival,
    output logic [15:0]              o_head_burst,
    output logic [7:0]               o_head_priority,
    output logic                     o_is_empty,
    output logic [ENTRY_W-1:0]       o_entry_total,
    output logic [1:0]               o_status
);

    t_rec                   w_new;
    t_rec                   w_rec [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_gt;
    t_cell_ctl              w_ctl;
    logic                   w_take;
    logic                   w_full;
    logic                   w_empty;

    logic                   r_strobe;
    t_status                r_status, n_status;
    logic [CNT_W-1:0]       r_count, n_count;

    assign busy    = 1'b0;
    assign w_take  = start && !busy;
    assign w_full  = w_valid[QUEUE_DEPTH-1];
    assign w_empty = !w_valid[0];

    assign w_new.id      = i_proc_id;
    assign w_new.arrival = i_arrival_time;
    assign w_new.burst   = i_burst_length;
    assign w_new.prio    = i_prio_level;

    always_comb begin
        w_ctl    = '0;
        n_status = ST_OK;
        n_count  = r_count;
        if (w_take) begin
            unique case (t_op'(i_operation))
                OP_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.pop = 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_rec l_prev_rec, l_next_rec;
            logic l_prev_valid, l_prev_gt, l_next_valid;

            if (gi == 0) begin : g_first
                assign l_prev_rec   = w_new;
                assign l_prev_valid = 1'b1;
                assign l_prev_gt    = 1'b0;
            end else begin : g_mid
                assign l_prev_rec   = w_rec[gi-1];
                assign l_prev_valid = w_valid[gi-1];
                assign l_prev_gt    = w_gt[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign l_next_rec   = w_new;
                assign l_next_valid = 1'b0;
            end else begin : g_body
                assign l_next_rec   = w_rec[gi+1];
                assign l_next_valid = w_valid[gi+1];
            end

            aoq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_prev_rec   (l_prev_rec),
                .i_prev_valid (l_prev_valid),
                .i_prev_gt    (l_prev_gt),
                .i_next_rec   (l_next_rec),
                .i_next_valid (l_next_valid),
                .o_rec        (w_rec[gi]),
                .o_valid      (w_valid[gi]),
                .o_gt         (w_gt[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_status <= ST_OK;
            r_count  <= '0;
        end else begin
            r_strobe <= w_take;
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_is_empty      = w_empty;
    assign o_head_id       = w_empty ? 8'd0  : w_rec[0].id;
    assign o_head_arrival  = w_empty ? 16'd0 : w_rec[0].arrival;
    assign o_head_burst    = w_empty ? 16'd0 : w_rec[0].burst;
    assign o_head_priority = w_empty ? 8'd0  : w_rec[0].prio;
    assign o_entry_total   = ENTRY_W'(r_count);
    assign o_status        = r_status;

    // count tracks the occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(w_valid))
        else $error("record count out of step with occupied cells");

    // occupied cells form a contiguous run from the head
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("gap in occupied cells");

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_strobe)
        else $error("request without result strobe");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_operation && w_full) |=> (o_status == ST_FULL && $stable(w_valid)))
        else $error("insert on full queue not dropped");

    // sorted order between the first two cells
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> !rec_after(w_rec[0], w_rec[1]))
        else $error("head out of order");

endmodule

`default_nettype wire

/* rtl/core/aoq_cell.sv */
`default_nettype none

module aoq_cell
    import aoq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_rec      i_new,
    input  wire t_rec      i_prev_rec,
    input  wire logic      i_prev_valid,
    input  wire logic      i_prev_gt,
    input  wire t_rec      i_next_rec,
    input  wire logic      i_next_valid,
    output t_rec           o_rec,
    output logic           o_valid,
    output logic           o_gt
);

    t_rec r_rec, n_rec;
    logic r_valid, n_valid;

    // an empty slot counts as later than any record
    assign o_gt    = !r_valid || rec_after(r_rec, i_new);
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_rec = i_prev_rec;
            end else if (o_gt) begin
                n_rec = i_new;
            end
            n_valid = r_valid || i_prev_valid;
        end else if (i_ctl.pop) begin
            n_rec   = i_next_rec;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

`default_nettype wire

/* tb/sv/arrival_ordered_queue_tb.sv */
`timescale 1ns / 100ps

module arrival_ordered_queue_tb;
    import aoq_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_ITEMS    = 800;

    typedef struct packed {
        logic [7:0]         id;
        logic [15:0]        arrival;
        logic [15:0]        burst;
        logic [7:0]         prio;
        logic               is_empty;
        logic [ENTRY_W-1:0] total;
        t_status            status;
    } t_head_report;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [7:0]         i_proc_id;
    logic [15:0]        i_arrival_time;
    logic [15:0]        i_burst_length;
    logic [7:0]         i_prio_level;
    logic               o_strobe;
    logic [7:0]         o_head_id;
    logic [15:0]        o_head_arrival;
    logic [15:0]        o_head_burst;
    logic [7:0]         o_head_priority;
    logic               o_is_empty;
    logic [ENTRY_W-1:0] o_entry_total;
    logic [1:0]         o_status;

    // sorted image of the queue contents, index 0 is the head
    t_rec         queue_image[$];
    t_head_report reports_due[$];

    int mismatch_total  = 0;
    int results_checked = 0;
    int insert_total    = 0;
    int pop_total       = 0;
    int full_drops      = 0;
    int empty_pops      = 0;
    int stalled_cycles  = 0;

    arrival_ordered_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_proc_id       (i_proc_id),
        .i_arrival_time  (i_arrival_time),
        .i_burst_length  (i_burst_length),
        .i_prio_level    (i_prio_level),
        .o_strobe        (o_strobe),
        .o_head_id       (o_head_id),
        .o_head_arrival  (o_head_arrival),
        .o_head_burst    (o_head_burst),
        .o_head_priority (o_head_priority),
        .o_is_empty      (o_is_empty),
        .o_entry_total   (o_entry_total),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [23:0] order_key(input t_rec r);
        return {r.arrival, r.id};
    endfunction

    // applies one request to the queue image and returns the head report it yields
    function automatic t_head_report apply_request(input t_op op, input t_rec rec);
        t_head_report rpt;
        int           pos;
        rpt        = '0;
        rpt.status = ST_OK;
        if (op == OP_INSERT) begin
            insert_total++;
            if (queue_image.size() >= QUEUE_DEPTH) begin
                rpt.status = ST_FULL;
                full_drops++;
            end else begin
                // equal keys: new record goes behind the ones already held
                pos = queue_image.size();
                while (pos > 0 && order_key(queue_image[pos-1]) > order_key(rec))
                    pos--;
                queue_image.insert(pos, rec);
            end
        end else begin
            pop_total++;
            if (queue_image.size() == 0) begin
                rpt.status = ST_EMPTY;
                empty_pops++;
            end else begin
                void'(queue_image.pop_front());
            end
        end
        if (queue_image.size() > 0) begin
            rpt.id       = queue_image[0].id;
            rpt.arrival  = queue_image[0].arrival;
            rpt.burst    = queue_image[0].burst;
            rpt.prio     = queue_image[0].prio;
            rpt.is_empty = 1'b0;
        end else begin
            rpt.is_empty = 1'b1;
        end
        rpt.total = ENTRY_W'(queue_image.size());
        return rpt;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_head_report due;
        logic         bad;
        if (i_rst_n) begin
            if (start && !busy) begin
                reports_due.push_back(apply_request(t_op'(i_operation),
                    t_rec'{id: i_proc_id, arrival: i_arrival_time,
                           burst: i_burst_length, prio: i_prio_level}));
            end
            if (o_strobe) begin
                if (reports_due.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("ERROR: result strobe with no request pending");
                end else begin
                    due = reports_due.pop_front();
                    results_checked++;
                    bad = (o_head_id !== due.id) || (o_head_arrival !== due.arrival) ||
                          (o_head_burst !== due.burst) || (o_head_priority !== due.prio) ||
                          (o_is_empty !== due.is_empty) || (o_entry_total !== due.total) ||
                          (o_status !== due.status);
                    if (bad) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $display({"ERROR: result %0d exp id=%h arr=%h burst=%h",
                                      " pri=%h empty=%b cnt=%0d st=%0d"},
                                     results_checked, due.id, due.arrival, due.burst,
                                     due.prio, due.is_empty, due.total, due.status);
                            $display({"       got id=%h arr=%h burst=%h pri=%h",
                                      " empty=%b cnt=%0d st=%0d"},
                                     o_head_id, o_head_arrival, o_head_burst,
                                     o_head_priority, o_is_empty, o_entry_total, o_status);
                        end
                    end
                end
            end
        end
        if ((start && !busy) || o_strobe) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_CYCLES) begin
                $display("ERROR: no activity for %0d cycles, %0d results outstanding",
                         stalled_cycles, reports_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_request(input t_op op, input t_rec rec);
        @(negedge i_clk);
        start          <= 1'b1;
        i_operation    <= op;
        i_proc_id      <= rec.id;
        i_arrival_time <= rec.arrival;
        i_burst_length <= rec.burst;
        i_prio_level   <= rec.prio;
        do @(posedge i_clk); while (busy);
    endtask

    // idle the request side, with junk on the payload, when n is above zero
    task automatic hold_off(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_operation    <= 1'($urandom);
            i_proc_id      <= 8'($urandom);
            i_arrival_time <= 16'($urandom);
            i_burst_length <= 16'($urandom);
            i_prio_level   <= 8'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // keys bunched on a few values so that ties on arrival and id are common
    function automatic t_rec random_record();
        t_rec r;
        case ($urandom_range(3))
            0:       r.arrival = 16'($urandom_range(3));
            1:       r.arrival = 16'hFFFF - 16'($urandom_range(1));
            default: r.arrival = 16'($urandom);
        endcase
        r.id    = $urandom_range(1) ? 8'($urandom_range(2)) : 8'($urandom);
        r.burst = 16'($urandom);
        r.prio  = 8'($urandom);
        return r;
    endfunction

    task automatic test_empty_pop();
        send_request(OP_POP, random_record());
        send_request(OP_POP, t_rec'('1));
    endtask

    task automatic test_sort_order();
        send_request(OP_INSERT, t_rec'{id: 8'hFF, arrival: 16'hFFFF, burst: 16'hFFFF, prio: 8'hFF});
        send_request(OP_INSERT, t_rec'{id: 8'h00, arrival: 16'h0000, burst: 16'h0000, prio: 8'h00});
        send_request(OP_INSERT, t_rec'{id: 8'd9,  arrival: 16'd100, burst: 16'h1111, prio: 8'h11});
        send_request(OP_INSERT, t_rec'{id: 8'd3,  arrival: 16'd100, burst: 16'h2222, prio: 8'h22});
        // same arrival and id: must queue behind the earlier one
        send_request(OP_INSERT, t_rec'{id: 8'd3,  arrival: 16'd100, burst: 16'h3333, prio: 8'h33});
        send_request(OP_INSERT, t_rec'{id: 8'd200, arrival: 16'd99, burst: 16'h4444, prio: 8'h44});
        send_request(OP_POP, random_record());
    endtask

    task automatic test_full_drop();
        int room;
        wait_until_drained();
        room = QUEUE_DEPTH - queue_image.size();
        repeat (room) send_request(OP_INSERT, random_record());
        send_request(OP_INSERT, random_record());
        send_request(OP_INSERT, t_rec'{id: 8'h00, arrival: 16'h0000, burst: 16'hAAAA, prio: 8'h55});
        repeat (3) send_request(OP_POP, random_record());
    endtask

    // rounds that lean toward filling, draining or a mix, some without gaps
    task automatic test_random_traffic(input int items);
        int sent;
        int rounds;
        int insert_pct;
        int round_len;
        bit steady;
        sent   = 0;
        rounds = 0;
        while (sent < items) begin
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            round_len = $urandom_range(40, 8);
            steady    = ($urandom_range(3) == 0);
            repeat (round_len) begin
                send_request(t_op'(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP),
                             random_record());
                hold_off(steady ? 0 : pick_gap());
                sent++;
            end
            rounds++;
            if (rounds % 6 == 0) wait_until_drained();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = 1'b0;
        i_proc_id      = '0;
        i_arrival_time = '0;
        i_burst_length = '0;
        i_prio_level   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pop();
        test_sort_order();
        test_full_drop();
        test_random_traffic(RANDOM_ITEMS);

        wait_until_drained();
        repeat (4) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            mismatch_total += reports_due.size();
            $display("ERROR: %0d results never arrived", reports_due.size());
        end

        $display("Ran %0d requests (%0d inserts, %0d pops), checked %0d head reports",
                 insert_total + pop_total, insert_total, pop_total, results_checked);
        $display("%0d inserts dropped on full, %0d pops on empty, %0d mismatches",
                 full_drops, empty_pops, mismatch_total);
        if (mismatch_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/aoq_pkg.sv
rtl/core/aoq_cell.sv
rtl/core/arrival_ordered_queue.sv
tb/sv/arrival_ordered_queue_tb.sv
